// ----- rtl/dlshg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dlshg_pkg
// Types and constants of the dual-layer spatial hash grid.
// ----------------------------------------------------------------------------
package dlshg_pkg;

  localparam int HASH_BUCKETS  = 1024;
  localparam int HB_W          = $clog2(HASH_BUCKETS);
  localparam int STATIC_NODES  = 4096;
  localparam int SN_W          = $clog2(STATIC_NODES);
  localparam int DYNAMIC_NODES = 2048;
  localparam int DN_W          = $clog2(DYNAMIC_NODES);
  localparam int RESULT_LIMIT  = 63;
  localparam int RL_W          = 6;

  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;

  // static link/head: SN_W+1 bits, null is STATIC_NODES
  localparam logic [SN_W:0] S_NULL = (SN_W + 1)'(STATIC_NODES);
  localparam logic [DN_W:0] D_NULL = (DN_W + 1)'(DYNAMIC_NODES);

  localparam logic [2:0] K_CLEAR_ALL  = 3'd0;
  localparam logic [2:0] K_CLEAR_DYN  = 3'd1;
  localparam logic [2:0] K_ADD_STATIC = 3'd2;
  localparam logic [2:0] K_ADD_DYN    = 3'd3;
  localparam logic [2:0] K_REMOVE     = 3'd4;
  localparam logic [2:0] K_QUERY      = 3'd5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_CUT  = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_BUCKET, ST_ADD, ST_NEXT,
    ST_RHEAD, ST_RREAD, ST_RCMP, ST_RFREE,
    ST_QHEAD, ST_QREAD, ST_QCMP, ST_QSCAN, ST_QSCMP, ST_QINS,
    ST_CLOSE, ST_ORD, ST_OLD, ST_LAST
  } state_t;

  typedef struct packed {
    logic [31:0] ent;
    logic [15:0] cx;
    logic [15:0] cy;
  } node_t;

  typedef struct packed {
    logic [31:0] ent;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [DN_W:0] link;
  } dnode_t;

endpackage : dlshg_pkg
`default_nettype wire

// ----- rtl/dual_layer_spatial_hash_grid_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dual_layer_spatial_hash_grid_unit
// Broad-phase spatial hash, static and dynamic layers with chained buckets.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                 | payload
//  s_axis   | in  | s_axis_tvalid/tready      | tdata: cmd fields, tuser: kind
//  m_axis   | out | m_axis_tvalid/tready      | tdata: found_id, tuser, tlast
//  cfg      | in  | cfg_valid/cfg_ready       | cfg_data: grid_shift
//
//  A command is accepted, then each cell is hashed, its bucket read and the
//  walk stepped; add writes a node, remove unlinks and frees static matches,
//  query walks both chains and, on a match, scans the seen entries and
//  inserts. Walking commands then close and send each result and the last
//  beat. The node memories' single read port sets the walk rate. Reset and
//  clear-all sweep both head tables, clear-dynamic the dynamic one, taking
//  no command. A stalled m_axis holds the sequencer at the next beat.
// ----------------------------------------------------------------------------
module dual_layer_spatial_hash_grid_unit
  import dlshg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] entity_id, [62:32] pos_x, [93:63] pos_y, [105:94] extent_w,
  // [117:106] extent_h, [123:118] result_cap, [127:124] zero
  input  wire logic [127:0] s_axis_tdata,
  // [2:0] kind
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] found_id
  output logic [31:0]       m_axis_tdata,
  // [0] has_entity, [2:1] status
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data
);

  state_t state, state_next;

  logic [3:0]  grid_shift;
  logic [2:0]  kind_r, kind_r_next;
  logic [31:0] ent, ent_next;
  logic [RL_W-1:0] cap, cap_next, count, count_next, k, k_next;
  logic signed [31:0] x0, x0_next, x1, x1_next, y1, y1_next;
  logic signed [31:0] cx, cx_next, cy, cy_next;
  logic [31:0] h1, h2;
  logic [HB_W-1:0] bucket, bucket_c, clr_idx, clr_idx_next;
  logic clr_static, clr_static_next, clr_boot, clr_boot_next;
  logic [SN_W:0] cur, cur_next, prev, prev_next, nx, nx_next;
  logic [SN_W:0] free_head, free_head_next, s_alloc, s_alloc_next;
  logic [DN_W:0] d_alloc, d_alloc_next, dhead, dhead_next;
  logic layer, layer_next;
  logic [1:0] status, status_next;

  logic        out_load;
  logic [31:0] out_id;
  logic        out_has, out_last;
  logic [1:0]  out_stat;
  logic        out_free;

  // memories
  logic [SN_W:0]   sh_mem [HASH_BUCKETS];
  logic [DN_W:0]   dh_mem [HASH_BUCKETS];
  node_t           sn_mem [STATIC_NODES];
  logic [SN_W:0]   snl_mem [STATIC_NODES];
  dnode_t          dn_mem [DYNAMIC_NODES];
  logic [31:0]     seen_mem [RESULT_LIMIT];

  logic [SN_W:0]   sh_rd;
  logic [DN_W:0]   dh_rd;
  node_t           sn_rd;
  logic [SN_W:0]   snl_rd;
  dnode_t          dn_rd;
  logic [31:0]     seen_rd;

  logic            sh_we, dh_we, sn_we, snl_we, dn_we, seen_we;
  logic [HB_W-1:0] h_waddr;
  logic [SN_W:0]   sh_wdata, snl_wdata;
  logic [DN_W:0]   dh_wdata;
  logic [SN_W-1:0] sn_waddr, snl_waddr, sn_raddr;
  node_t           sn_wdata;
  dnode_t          dn_wdata;

  // command decode at acceptance
  logic signed [31:0] px_e, py_e, pxr_e, pyb_e;
  logic [RL_W-1:0]    cap_in;
  logic               in_acc;

  // node compare
  node_t         nd;
  logic [SN_W:0] nd_link;
  logic          cell_hit, cur_null, last_cell;

  assign bucket_c = HB_W'((h1 ^ h2) % HASH_BUCKETS);

  assign px_e  = 32'(signed'(s_axis_tdata[62:32]));
  assign py_e  = 32'(signed'(s_axis_tdata[93:63]));
  assign pxr_e = px_e + signed'({20'd0, s_axis_tdata[105:94]});
  assign pyb_e = py_e + signed'({20'd0, s_axis_tdata[117:106]});
  assign cap_in = (s_axis_tdata[123:118] > RL_W'(RESULT_LIMIT)) ?
                  RL_W'(RESULT_LIMIT) : s_axis_tdata[123:118];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign last_cell     = (cx == x1) && (cy == y1);

  always_comb begin
    if (layer) begin
      nd      = '{ent: dn_rd.ent, cx: dn_rd.cx, cy: dn_rd.cy};
      nd_link = (SN_W + 1)'(dn_rd.link);
      cur_null = (cur >= (SN_W + 1)'(DYNAMIC_NODES));
    end else begin
      nd      = sn_rd;
      nd_link = snl_rd;
      cur_null = (cur >= S_NULL);
    end
    cell_hit = (32'(signed'(nd.cx)) == cx) && (32'(signed'(nd.cy)) == cy);
  end

  always_comb begin
    state_next      = state;
    kind_r_next     = kind_r;
    ent_next        = ent;
    cap_next        = cap;
    count_next      = count;
    k_next          = k;
    x0_next         = x0;
    x1_next         = x1;
    y1_next         = y1;
    cx_next         = cx;
    cy_next         = cy;
    clr_idx_next    = clr_idx;
    clr_static_next = clr_static;
    clr_boot_next   = clr_boot;
    cur_next        = cur;
    prev_next       = prev;
    nx_next         = nx;
    free_head_next  = free_head;
    s_alloc_next    = s_alloc;
    d_alloc_next    = d_alloc;
    dhead_next      = dhead;
    layer_next      = layer;
    status_next     = status;
    out_load  = 1'b0;
    out_id    = '0;
    out_has   = 1'b0;
    out_stat  = STAT_OK;
    out_last  = 1'b0;
    sh_we     = 1'b0;
    dh_we     = 1'b0;
    sn_we     = 1'b0;
    snl_we    = 1'b0;
    dn_we     = 1'b0;
    seen_we   = 1'b0;
    h_waddr   = bucket;
    sh_wdata  = S_NULL;
    dh_wdata  = D_NULL;
    sn_waddr  = cur[SN_W-1:0];
    sn_wdata  = '{ent: ent, cx: cx[15:0], cy: cy[15:0]};
    snl_waddr = cur[SN_W-1:0];
    snl_wdata = free_head;
    dn_wdata  = '{ent: ent, cx: cx[15:0], cy: cy[15:0], link: dh_rd};
    sn_raddr  = cur[SN_W-1:0];

    case (state)
      ST_CLEAR: begin
        h_waddr = clr_idx;
        dh_we   = 1'b1;
        sh_we   = clr_static;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == HB_W'(HASH_BUCKETS - 1)) begin
          state_next    = clr_boot ? ST_IDLE : ST_LAST;
          clr_boot_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          kind_r_next = s_axis_tuser;
          ent_next    = s_axis_tdata[31:0];
          cap_next    = cap_in;
          count_next  = '0;
          status_next = STAT_OK;
          x0_next     = px_e >>> grid_shift;
          cx_next     = px_e >>> grid_shift;
          x1_next     = pxr_e >>> grid_shift;
          cy_next     = py_e >>> grid_shift;
          y1_next     = pyb_e >>> grid_shift;
          clr_idx_next = '0;
          case (s_axis_tuser)
            K_CLEAR_ALL: begin
              clr_static_next = 1'b1;
              s_alloc_next    = '0;
              d_alloc_next    = '0;
              free_head_next  = S_NULL;
              state_next      = ST_CLEAR;
            end
            K_CLEAR_DYN: begin
              clr_static_next = 1'b0;
              d_alloc_next    = '0;
              state_next      = ST_CLEAR;
            end
            K_ADD_STATIC, K_ADD_DYN, K_REMOVE, K_QUERY: state_next = ST_HASH;
            default: state_next = ST_LAST;
          endcase
        end
      end
      ST_HASH: state_next = ST_BUCKET;
      ST_BUCKET: begin
        sn_raddr = free_head[SN_W-1:0];
        case (kind_r)
          K_ADD_STATIC: begin
            if (free_head >= S_NULL && s_alloc >= S_NULL) begin
              status_next = STAT_FULL;
              state_next  = ST_CLOSE;
            end else begin
              state_next = ST_ADD;
            end
          end
          K_ADD_DYN: begin
            if (d_alloc >= D_NULL) begin
              status_next = STAT_FULL;
              state_next  = ST_CLOSE;
            end else begin
              state_next = ST_ADD;
            end
          end
          K_REMOVE: state_next = ST_RHEAD;
          default:  state_next = ST_QHEAD;
        endcase
      end
      ST_ADD: begin
        if (kind_r == K_ADD_STATIC) begin
          if (free_head < S_NULL) begin
            sn_waddr       = free_head[SN_W-1:0];
            free_head_next = snl_rd;
          end else begin
            sn_waddr     = s_alloc[SN_W-1:0];
            s_alloc_next = s_alloc + 1'b1;
          end
          snl_waddr = sn_waddr;
          snl_wdata = sh_rd;
          sn_we     = 1'b1;
          snl_we    = 1'b1;
          sh_we     = 1'b1;
          sh_wdata  = {1'b0, sn_waddr};
        end else begin
          dn_we        = 1'b1;
          dh_we        = 1'b1;
          dh_wdata     = d_alloc;
          d_alloc_next = d_alloc + 1'b1;
        end
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (last_cell) begin
          state_next = ST_CLOSE;
        end else begin
          if (cx == x1) begin
            cx_next = x0;
            cy_next = cy + 1'b1;
          end else begin
            cx_next = cx + 1'b1;
          end
          state_next = ST_HASH;
        end
      end
      ST_RHEAD: begin
        cur_next   = sh_rd;
        prev_next  = S_NULL;
        layer_next = 1'b0;
        state_next = ST_RREAD;
      end
      ST_RREAD: state_next = cur_null ? ST_NEXT : ST_RCMP;
      ST_RCMP: begin
        if (cell_hit && nd.ent == ent) begin
          nx_next = nd_link;
          if (prev >= S_NULL) begin
            sh_we    = 1'b1;
            sh_wdata = nd_link;
          end else begin
            snl_we    = 1'b1;
            snl_waddr = prev[SN_W-1:0];
            snl_wdata = nd_link;
          end
          state_next = ST_RFREE;
        end else begin
          prev_next  = cur;
          cur_next   = nd_link;
          state_next = ST_RREAD;
        end
      end
      ST_RFREE: begin
        snl_we         = 1'b1;
        free_head_next = cur;
        cur_next       = nx;
        state_next     = ST_RREAD;
      end
      ST_QHEAD: begin
        cur_next   = sh_rd;
        dhead_next = dh_rd;
        layer_next = 1'b0;
        state_next = ST_QREAD;
      end
      ST_QREAD: begin
        if (cur_null) begin
          if (!layer) begin
            layer_next = 1'b1;
            cur_next   = (SN_W + 1)'(dhead);
          end else begin
            state_next = ST_NEXT;
          end
        end else begin
          state_next = ST_QCMP;
        end
      end
      ST_QCMP: begin
        nx_next = nd_link;
        if (cell_hit) begin
          ent_next   = nd.ent;
          k_next     = '0;
          state_next = (count == '0) ? ST_QINS : ST_QSCAN;
        end else begin
          cur_next   = nd_link;
          state_next = ST_QREAD;
        end
      end
      ST_QSCAN: state_next = ST_QSCMP;
      ST_QSCMP: begin
        if (seen_rd == ent) begin
          cur_next   = nx;
          state_next = ST_QREAD;
        end else if (k + 1'b1 == count) begin
          state_next = ST_QINS;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_QSCAN;
        end
      end
      ST_QINS: begin
        if (count >= cap) begin
          status_next = STAT_CUT;
          state_next  = ST_CLOSE;
        end else begin
          seen_we    = 1'b1;
          count_next = count + 1'b1;
          cur_next   = nx;
          state_next = ST_QREAD;
        end
      end
      ST_CLOSE: begin
        k_next     = '0;
        state_next = (count == '0) ? ST_LAST : ST_ORD;
      end
      ST_ORD: state_next = ST_OLD;
      ST_OLD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_id   = seen_rd;
          out_has  = 1'b1;
          k_next   = k + 1'b1;
          state_next = (k + 1'b1 == count) ? ST_LAST : ST_ORD;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_stat   = status;
          out_last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_boot   <= 1'b1;
      clr_static <= 1'b1;
      clr_idx    <= '0;
      free_head  <= S_NULL;
      s_alloc    <= '0;
      d_alloc    <= '0;
      grid_shift <= 4'd6;
      m_axis_tvalid <= 1'b0;
      count      <= '0;
      status     <= STAT_OK;
      kind_r     <= K_CLEAR_ALL;
    end else begin
      state      <= state_next;
      clr_boot   <= clr_boot_next;
      clr_static <= clr_static_next;
      clr_idx    <= clr_idx_next;
      free_head  <= free_head_next;
      s_alloc    <= s_alloc_next;
      d_alloc    <= d_alloc_next;
      count      <= count_next;
      status     <= status_next;
      kind_r     <= kind_r_next;
      if (cfg_valid && cfg_ready) grid_shift <= cfg_data;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent   <= ent_next;
    cap   <= cap_next;
    k     <= k_next;
    x0    <= x0_next;
    x1    <= x1_next;
    y1    <= y1_next;
    cx    <= cx_next;
    cy    <= cy_next;
    cur   <= cur_next;
    prev  <= prev_next;
    nx    <= nx_next;
    dhead <= dhead_next;
    layer <= layer_next;
    bucket <= bucket_c;
    h1 <= cx * HASH_MUL_X;
    h2 <= cy * HASH_MUL_Y;
    if (out_load) begin
      m_axis_tdata <= out_id;
      m_axis_tuser <= {out_stat, out_has};
      m_axis_tlast <= out_last;
    end
  end

  // head tables
  always_ff @(posedge clk) begin
    if (sh_we) sh_mem[h_waddr] <= sh_wdata;
    if (dh_we) dh_mem[h_waddr] <= dh_wdata;
    sh_rd <= sh_mem[bucket_c];
    dh_rd <= dh_mem[bucket_c];
  end

  // node pools
  always_ff @(posedge clk) begin
    if (sn_we)  sn_mem[sn_waddr]   <= sn_wdata;
    if (snl_we) snl_mem[snl_waddr] <= snl_wdata;
    if (dn_we)  dn_mem[d_alloc[DN_W-1:0]] <= dn_wdata;
    sn_rd  <= sn_mem[sn_raddr];
    snl_rd <= snl_mem[sn_raddr];
    dn_rd  <= dn_mem[cur[DN_W-1:0]];
  end

  // query result scratch
  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[count] <= ent;
    seen_rd <= seen_mem[k];
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_CLEAR) |-> (count <= cap))
    else $error("result count above cap");

  a_pools: assert property (@(posedge clk) disable iff (rst)
    (s_alloc <= S_NULL) && (d_alloc <= D_NULL))
    else $error("allocation count beyond pool");

  a_cut_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LAST && status == STAT_CUT) |-> (kind_r == K_QUERY))
    else $error("cap status on a non-query command");

  a_full_add: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LAST && status == STAT_FULL) |->
      (kind_r == K_ADD_STATIC || kind_r == K_ADD_DYN))
    else $error("pool-full status on a non-add command");

endmodule : dual_layer_spatial_hash_grid_unit
`default_nettype wire

// ----- test/dlshg_checker.sv -----
// ----------------------------------------------------------------------------
// dlshg_checker
// Watches the command, result and register channels of the spatial hash grid,
// keeps its own copy of both layers and compares every result beat in order.
// ----------------------------------------------------------------------------
module dlshg_checker
  import dlshg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic [2:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [31:0]  m_axis_tdata,
  input  wire logic [2:0]   m_axis_tuser,
  input  wire logic         m_axis_tlast,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [3:0]   cfg_data,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [31:0] id;
    logic        has;
    logic [1:0]  status;
    logic        last;
  } beat_t;

  beat_t       exp_q[$];
  logic [3:0]  shift_r;
  int          s_head[HASH_BUCKETS];
  int          d_head[HASH_BUCKETS];
  logic [31:0] s_ent[STATIC_NODES];
  logic [15:0] s_cx[STATIC_NODES], s_cy[STATIC_NODES];
  int          s_link[STATIC_NODES];
  logic [31:0] d_ent[DYNAMIC_NODES];
  logic [15:0] d_cx[DYNAMIC_NODES], d_cy[DYNAMIC_NODES];
  int          d_link[DYNAMIC_NODES];
  int          s_alloc, d_alloc, s_free;

  function automatic longint cell_of(longint v, logic [3:0] s);
    return v >>> s;
  endfunction

  function automatic int bucket_of(longint cx, longint cy);
    logic [31:0] h;
    h = (32'(cx) * HASH_MUL_X) ^ (32'(cy) * HASH_MUL_Y);
    return int'(h % HASH_BUCKETS);
  endfunction

  function automatic bit same_cell(logic [15:0] st, longint c);
    return longint'(signed'(st)) == c;
  endfunction

  task automatic wipe_dynamic();
    foreach (d_head[i]) d_head[i] = DYNAMIC_NODES;
    d_alloc = 0;
  endtask

  task automatic wipe_static();
    foreach (s_head[i]) s_head[i] = STATIC_NODES;
    s_alloc = 0;
    s_free  = STATIC_NODES;
  endtask

  task automatic apply_command(logic [2:0] kind, logic [127:0] d);
    logic [31:0] ent;
    longint      px, py, x0, y0, x1, y1, cx, cy;
    int          cap, b, n, prv, cur, nx, lay, steps;
    logic [1:0]  st;
    logic [31:0] seen[$];
    bit          stop, dup;
    ent  = d[31:0];
    px   = longint'(signed'(d[62:32]));
    py   = longint'(signed'(d[93:63]));
    cap  = d[123:118];
    if (cap > RESULT_LIMIT) cap = RESULT_LIMIT;
    x0 = cell_of(px, shift_r);
    y0 = cell_of(py, shift_r);
    x1 = cell_of(px + d[105:94], shift_r);
    y1 = cell_of(py + d[117:106], shift_r);
    st = STAT_OK;
    stop = 0;
    if (kind == K_CLEAR_ALL) begin
      wipe_static();
      wipe_dynamic();
    end else if (kind == K_CLEAR_DYN) begin
      wipe_dynamic();
    end else if (kind inside {K_ADD_STATIC, K_ADD_DYN, K_REMOVE, K_QUERY}) begin
      for (cy = y0; cy <= y1 && !stop; cy++) begin
        for (cx = x0; cx <= x1 && !stop; cx++) begin
          b = bucket_of(cx, cy);
          if (kind == K_ADD_STATIC) begin
            if (s_free < STATIC_NODES) begin
              n = s_free;
              s_free = s_link[n];
            end else if (s_alloc < STATIC_NODES) begin
              n = s_alloc++;
            end else begin
              st = STAT_FULL;
              stop = 1;
              break;
            end
            s_ent[n] = ent; s_cx[n] = cx[15:0]; s_cy[n] = cy[15:0];
            s_link[n] = s_head[b];
            s_head[b] = n;
          end else if (kind == K_ADD_DYN) begin
            if (d_alloc >= DYNAMIC_NODES) begin
              st = STAT_FULL;
              stop = 1;
              break;
            end
            n = d_alloc++;
            d_ent[n] = ent; d_cx[n] = cx[15:0]; d_cy[n] = cy[15:0];
            d_link[n] = d_head[b];
            d_head[b] = n;
          end else if (kind == K_REMOVE) begin
            prv = STATIC_NODES;
            cur = s_head[b];
            for (steps = 0; cur < STATIC_NODES && steps < STATIC_NODES; steps++) begin
              nx = s_link[cur];
              if (s_ent[cur] == ent && same_cell(s_cx[cur], cx) &&
                  same_cell(s_cy[cur], cy)) begin
                if (prv >= STATIC_NODES) s_head[b] = nx;
                else s_link[prv] = nx;
                s_link[cur] = s_free;
                s_free = cur;
              end else begin
                prv = cur;
              end
              cur = nx;
            end
          end else begin
            for (lay = 0; lay < 2 && !stop; lay++) begin
              int lim;
              lim = lay ? DYNAMIC_NODES : STATIC_NODES;
              cur = lay ? d_head[b] : s_head[b];
              for (steps = 0; cur < lim && steps < lim; steps++) begin
                logic [15:0] gx, gy;
                logic [31:0] e;
                gx = lay ? d_cx[cur] : s_cx[cur];
                gy = lay ? d_cy[cur] : s_cy[cur];
                e  = lay ? d_ent[cur] : s_ent[cur];
                if (same_cell(gx, cx) && same_cell(gy, cy)) begin
                  dup = 0;
                  foreach (seen[k]) if (seen[k] == e) dup = 1;
                  if (!dup) begin
                    if (seen.size() >= cap) begin
                      st = STAT_CUT;
                      stop = 1;
                      break;
                    end
                    seen.push_back(e);
                  end
                end
                cur = lay ? d_link[cur] : s_link[cur];
              end
            end
          end
        end
      end
    end
    foreach (seen[k]) exp_q.push_back('{seen[k], 1'b1, STAT_OK, 1'b0});
    exp_q.push_back('{32'd0, 1'b0, st, 1'b1});
  endtask

  always @(posedge clk) begin
    beat_t want;
    int    errs;
    errs = 0;
    if (rst) begin
      shift_r    <= 4'd6;
      fail_count <= 0;
      pending    <= 0;
      exp_q.delete();
      wipe_static();
      wipe_dynamic();
    end else begin
      if (cfg_valid && cfg_ready) shift_r <= cfg_data;
      if (s_axis_tvalid && s_axis_tready) apply_command(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_q.size() == 0) begin
          $error("unexpected result beat id=%h", m_axis_tdata);
          errs++;
        end else begin
          want = exp_q.pop_front();
          if (want.id !== m_axis_tdata) begin
            $error("found_id: expected %h, got %h", want.id, m_axis_tdata);
            errs++;
          end
          if (want.has !== m_axis_tuser[0]) begin
            $error("has_entity: expected %b, got %b", want.has, m_axis_tuser[0]);
            errs++;
          end
          if (want.status !== m_axis_tuser[2:1]) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:1]);
            errs++;
          end
          if (want.last !== m_axis_tlast) begin
            $error("last: expected %b, got %b", want.last, m_axis_tlast);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= exp_q.size();
    end
  end

endmodule : dlshg_checker

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Spatial hash grid stimulus: directed corner commands, then random phases
// of adds, removes and queries over a small world, under varying back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import dlshg_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid, cfg_ready;
  logic [3:0]   cfg_data;
  int           fail_count, pending;
  int           cycle_count;
  int           send_idle, recv_stall;

  dual_layer_spatial_hash_grid_unit dut (.*);
  dlshg_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
    cycle_count   <= cycle_count + 1;
    if (cycle_count > 20000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // tvalid stays up after a beat so the next command can follow directly
  task automatic send_cmd(logic [2:0] kind, logic [31:0] ent, logic [30:0] px,
                          logic [30:0] py, logic [11:0] w, logic [11:0] h,
                          logic [5:0] cap);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'd0, cap, h, w, py, px, ent};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // block idle: nothing pending plus room for a head-table sweep
  task automatic drain();
    wait_empty();
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_shift(logic [3:0] s);
    cfg_valid <= 1'b1;
    cfg_data  <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_cmd(bit wide);
    logic [2:0]  kind;
    logic [30:0] px, py;
    int          r;
    r = $urandom_range(99);
    if (r < 35) kind = K_ADD_STATIC;
    else if (r < 55) kind = K_ADD_DYN;
    else if (r < 70) kind = K_REMOVE;
    else if (r < 96) kind = K_QUERY;
    else if (r < 98) kind = K_CLEAR_DYN;
    else kind = $urandom_range(1) ? K_CLEAR_ALL : 3'($urandom_range(7, 6));
    if (wide) begin
      px = $urandom;
      py = $urandom;
    end else begin
      px = 31'($signed($urandom_range(1024)) - 512);
      py = 31'($signed($urandom_range(1024)) - 512);
    end
    send_cmd(kind, wide ? $urandom : 32'($urandom_range(11)), px, py,
             12'($urandom_range(300)), 12'($urandom_range(300)),
             6'($urandom));
  endtask

  initial begin
    logic [3:0] shifts[4] = '{4'd6, 4'd3, 4'd15, 4'd7};
    int idles[4]  = '{0, 70, 0, 38};
    int stalls[4] = '{0, 0, 70, 38};
    rst = 1'b1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 0; cfg_valid = 0; cfg_data = '0;
    cycle_count = 0; send_idle = 0; recv_stall = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    drain();
    set_shift(4'd6);
    // directed corners
    send_cmd(K_QUERY, 32'd0, 31'h4000_0000, 31'h3FFF_FFFF, 12'hFFF, 12'd0, 6'd63);
    send_cmd(K_ADD_STATIC, 32'hFFFF_FFFF, 31'h3FFF_FFC0, 31'h4000_0000, 12'd0, 12'd0, 6'd0);
    send_cmd(K_QUERY, 32'd0, 31'h3FFF_FFC0, 31'h4000_0000, 12'd0, 12'd0, 6'd63);
    send_cmd(K_ADD_STATIC, 32'd1, 31'h7FFF_FFC0, 31'd0, 12'd100, 12'd100, 6'd0);
    send_cmd(K_ADD_DYN, 32'd2, 31'h7FFF_FFC0, 31'd0, 12'd100, 12'd0, 6'd0);
    send_cmd(K_ADD_DYN, 32'd1, 31'd0, 31'd0, 12'd0, 12'd0, 6'd0);
    send_cmd(K_QUERY, 32'd0, 31'h7FFF_FFC0, 31'd0, 12'd100, 12'd100, 6'd63);
    send_cmd(K_QUERY, 32'd0, 31'h7FFF_FFC0, 31'd0, 12'd100, 12'd100, 6'd1);
    send_cmd(K_QUERY, 32'd0, 31'h7FFF_FFC0, 31'd0, 12'd100, 12'd100, 6'd0);
    send_cmd(K_REMOVE, 32'd1, 31'h7FFF_FFC0, 31'd0, 12'd100, 12'd100, 6'd0);
    send_cmd(K_QUERY, 32'd0, 31'h7FFF_FFC0, 31'd0, 12'd100, 12'd100, 6'd63);
    send_cmd(3'd6, 32'd0, 31'd0, 31'd0, 12'd0, 12'd0, 6'd0);
    send_cmd(3'd7, 32'd0, 31'd0, 31'd0, 12'd0, 12'd0, 6'd0);
    // cell beyond 16 bits never matches
    send_cmd(K_ADD_STATIC, 32'd9, 31'h0040_0000, 31'd0, 12'd0, 12'd0, 6'd0);
    send_cmd(K_QUERY, 32'd0, 31'h0040_0000, 31'd0, 12'd0, 12'd0, 6'd63);
    // more than 63 entities in one cell, cut at the limit
    for (int i = 0; i < 66; i++)
      send_cmd(K_ADD_DYN, 32'(100 + i), 31'd5, 31'd5, 12'd0, 12'd0, 6'd0);
    send_cmd(K_QUERY, 32'd0, 31'd0, 31'd0, 12'd0, 12'd0, 6'h3F);
    send_cmd(K_CLEAR_DYN, 32'd0, 31'd0, 31'd0, 12'd0, 12'd0, 6'd0);
    drain();
    // pool exhaustion on both layers with large rectangles, then clear
    set_shift(4'd0);
    send_cmd(K_ADD_DYN, 32'd7, 31'd0, 31'd0, 12'd63, 12'd40, 6'd0);
    send_cmd(K_ADD_STATIC, 32'd8, 31'd0, 31'd0, 12'd63, 12'd70, 6'd0);
    send_cmd(K_REMOVE, 32'd8, 31'd0, 31'd0, 12'd63, 12'd3, 6'd0);
    send_cmd(K_ADD_STATIC, 32'd3, 31'd0, 31'd0, 12'd63, 12'd5, 6'd0);
    send_cmd(K_QUERY, 32'd0, 31'd0, 31'd0, 12'd3, 12'd3, 6'd10);
    send_cmd(K_CLEAR_ALL, 32'd0, 31'd0, 31'd0, 12'd0, 12'd0, 6'd0);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_shift(shifts[p]);
      send_idle  = idles[p];
      recv_stall = stalls[p];
      for (int i = 0; i < 68; i++) begin
        rand_cmd(i % 20 == 19);
        if (i == 40) wait_empty();
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : tb

// ----- sim.f -----
rtl/dlshg_pkg.sv
rtl/dual_layer_spatial_hash_grid_unit.sv
test/dlshg_checker.sv
test/tb.sv
